### rtl/core/srle_pkg.sv
// ----------------------------------------------------------------------------
// srle_pkg: shared definitions for the sprite row RLE decoder
// Field widths, size limits, decode phases and the saturating offset adder.
// ----------------------------------------------------------------------------
package srle_pkg;

    // Size limits on the width and height registers.
    localparam int WIDTH_LIMIT  = 1024;
    localparam int HEIGHT_LIMIT = 1024;

    // Field widths.
    localparam int CFG_W   = 11;
    localparam int CODE_W  = 8;
    localparam int ADDR_W  = 20;
    localparam int INDEX_W = 8;
    localparam int ROW_W   = 10;
    localparam int AREA_W  = 2 * CFG_W;

    // Packed widths of the stream data words.
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 40;

    // Configuration port.
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam logic [CFG_W-1:0]  WIDTH_CAP   = CFG_W'(WIDTH_LIMIT);
    localparam logic [CFG_W-1:0]  HEIGHT_CAP  = CFG_W'(HEIGHT_LIMIT);
    localparam logic [CFG_W-1:0]  WIDTH_RST   = CFG_W'(640);
    localparam logic [CFG_W-1:0]  HEIGHT_RST  = CFG_W'(480);
    localparam logic [ADDR_W-1:0] ADDR_MAX    = '1;
    localparam logic [ROW_W-1:0]  ROW_MAX     = '1;
    localparam logic [CODE_W-1:0] END_CODE    = 8'hFF;

    // Register indexes, taken from paddr[2].
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    // Result kinds.
    localparam logic KIND_PIXEL   = 1'b0;
    localparam logic KIND_ROW_END = 1'b1;

    typedef enum logic [1:0] {
        PH_SKIP  = 2'd0,
        PH_COUNT = 2'd1,
        PH_DATA  = 2'd2
    } phase_t;

    // Add with saturation at the largest address.
    function automatic logic [ADDR_W-1:0] sat_add(input logic [ADDR_W-1:0] a,
                                                  input logic [ADDR_W-1:0] b);
        logic [ADDR_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[ADDR_W] ? ADDR_MAX : sum[ADDR_W-1:0];
    endfunction

endpackage

### rtl/core/sprite_row_rle_decoder.sv
// ----------------------------------------------------------------------------
// sprite_row_rle_decoder: transparent sprite run-length decoder
// Turns a stream of encoded row bytes into pixel writes and row-end items.
// ----------------------------------------------------------------------------
// Path: a byte is held in the input register, decoded, and its item is
// then held in the result register until it is taken.
// Throughput: one byte per cycle, set by the single decode step between the
// input register and the result register; a full result register with
// m_tready low holds back only a byte that makes an item.
// Reset (aresetn low, synchronous): both stages empty, decoder at the start
// of a frame, frame_width back to 640 and frame_height back to 480.
module sprite_row_rle_decoder (
    input  logic                            aclk,
    input  logic                            aresetn,

    // Encoded byte input.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [srle_pkg::S_TDATA_W-1:0]  s_tdata,   // [7:0] code_byte
    input  logic                            s_tuser,   // [0] frame_start

    // Decoded result output.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [srle_pkg::M_TDATA_W-1:0]  m_tdata,   // [19:0] pixel_address,
                                                       // [27:20] pixel_index,
                                                       // [37:28] row_number,
                                                       // [38] out_of_range,
                                                       // [39] zero
    output logic                            m_tuser,   // [0] kind
    output logic                            m_tlast,   // frame_done

    // Configuration port.
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [srle_pkg::APB_AW-1:0]     paddr,
    input  logic [srle_pkg::APB_DW-1:0]     pwdata,
    output logic [srle_pkg::APB_DW-1:0]     prdata,
    output logic                            pready
);
    import srle_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers. Registers sit on word addresses; only
    // paddr[2] selects between them, the byte-lane bits are ignored.
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] frame_width_reg;
    logic [CFG_W-1:0] frame_height_reg;
    logic             cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= WIDTH_RST;
            frame_height_reg <= HEIGHT_RST;
        end else if (cfg_write) begin
            if (paddr[2] == REG_WIDTH) begin
                frame_width_reg <= pwdata[CFG_W-1:0];
            end else begin
                frame_height_reg <= pwdata[CFG_W-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == REG_HEIGHT) begin
            prdata = {{(APB_DW-CFG_W){1'b0}}, frame_height_reg};
        end else begin
            prdata = {{(APB_DW-CFG_W){1'b0}}, frame_width_reg};
        end
    end

    // Effective sizes after clamping, and the frame area in pixels.
    logic [CFG_W-1:0]  eff_width;
    logic [CFG_W-1:0]  eff_height;
    logic [AREA_W-1:0] area;

    assign eff_width  = (frame_width_reg  > WIDTH_CAP)  ? WIDTH_CAP  : frame_width_reg;
    assign eff_height = (frame_height_reg > HEIGHT_CAP) ? HEIGHT_CAP : frame_height_reg;
    assign area       = AREA_W'(eff_width) * AREA_W'(eff_height);

    // ------------------------------------------------------------------
    // Input register. It takes a new item whenever it is empty or its
    // current item is being decoded in this cycle.
    // ------------------------------------------------------------------
    logic              in_valid_reg;
    logic [CODE_W-1:0] in_code_reg;
    logic              in_start_reg;
    logic              proc_fire;
    logic              res_valid;
    logic              out_free;
    logic              m_valid_reg;

    assign out_free  = !m_valid_reg || m_tready;
    // An item that makes no result never waits for the output side.
    assign proc_fire = in_valid_reg && (!res_valid || out_free);
    assign s_tready  = !in_valid_reg || proc_fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_code_reg  <= s_tdata[CODE_W-1:0];
            in_start_reg <= s_tuser;
        end
    end

    // ------------------------------------------------------------------
    // Decoder state. A frame start clears it before the byte is decoded,
    // so the decode works on the cleared view.
    // ------------------------------------------------------------------
    phase_t            phase_reg, phase_next;
    logic [CODE_W-1:0] run_left_reg, run_left_next;
    logic [ADDR_W-1:0] pixel_offset_reg, pixel_offset_next;
    logic [ADDR_W-1:0] row_base_reg, row_base_next;
    logic [ROW_W-1:0]  row_count_reg, row_count_next;

    phase_t            cur_phase;
    logic [CODE_W-1:0] cur_run_left;
    logic [ADDR_W-1:0] cur_offset;
    logic [ADDR_W-1:0] cur_row_base;
    logic [ROW_W-1:0]  cur_row_count;
    logic [CODE_W-1:0] run_left_dec;
    logic [ADDR_W-1:0] next_row;

    assign cur_phase     = in_start_reg ? PH_SKIP : phase_reg;
    assign cur_run_left  = in_start_reg ? '0 : run_left_reg;
    assign cur_offset    = in_start_reg ? '0 : pixel_offset_reg;
    assign cur_row_base  = in_start_reg ? '0 : row_base_reg;
    assign cur_row_count = in_start_reg ? '0 : row_count_reg;
    assign run_left_dec  = cur_run_left - CODE_W'(1);
    assign next_row      = sat_add(cur_row_base, ADDR_W'(eff_width));

    // Next phase.
    always_comb begin
        unique case (cur_phase)
            PH_COUNT: begin
                phase_next = (in_code_reg == '0) ? PH_SKIP : PH_DATA;
            end
            PH_DATA: begin
                phase_next = (run_left_dec == '0) ? PH_SKIP : PH_DATA;
            end
            default: begin
                // Skip count; an unused phase code decodes the same way.
                phase_next = (in_code_reg == END_CODE) ? PH_SKIP : PH_COUNT;
            end
        endcase
    end

    // Datapath and result fields.
    logic              res_kind;
    logic [ADDR_W-1:0] res_addr;
    logic [INDEX_W-1:0] res_index;
    logic              res_done;
    logic              res_oor;

    always_comb begin
        run_left_next     = cur_run_left;
        pixel_offset_next = cur_offset;
        row_base_next     = cur_row_base;
        row_count_next    = cur_row_count;
        res_valid         = 1'b0;
        res_kind          = KIND_PIXEL;
        res_addr          = cur_offset;
        res_index         = in_code_reg;
        res_done          = 1'b0;
        res_oor           = 1'b0;
        unique case (cur_phase)
            PH_COUNT: begin
                run_left_next = in_code_reg;
            end
            PH_DATA: begin
                res_valid         = 1'b1;
                res_oor           = AREA_W'(cur_offset) >= area;
                pixel_offset_next = sat_add(cur_offset, ADDR_W'(1));
                run_left_next     = run_left_dec;
            end
            default: begin
                if (in_code_reg != END_CODE) begin
                    pixel_offset_next = sat_add(cur_offset, ADDR_W'(in_code_reg));
                end else begin
                    // Row end: jump to the start of the next row.
                    res_valid         = 1'b1;
                    res_kind          = KIND_ROW_END;
                    res_addr          = next_row;
                    res_index         = '0;
                    res_done          = ({1'b0, cur_row_count} + CFG_W'(1)) == eff_height;
                    res_oor           = AREA_W'(next_row) > area;
                    row_base_next     = next_row;
                    pixel_offset_next = next_row;
                    run_left_next     = '0;
                    if (cur_row_count < ROW_MAX) begin
                        row_count_next = cur_row_count + ROW_W'(1);
                    end
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_SKIP;
            run_left_reg     <= '0;
            pixel_offset_reg <= '0;
            row_base_reg     <= '0;
            row_count_reg    <= '0;
        end else if (proc_fire) begin
            phase_reg        <= phase_next;
            run_left_reg     <= run_left_next;
            pixel_offset_reg <= pixel_offset_next;
            row_base_reg     <= row_base_next;
            row_count_reg    <= row_count_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register.
    // ------------------------------------------------------------------
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic                 m_tuser_reg;
    logic                 m_tlast_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= proc_fire && res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && proc_fire && res_valid) begin
            m_tdata_reg <= {1'b0, res_oor, cur_row_count, res_index, res_addr};
            m_tuser_reg <= res_kind;
            m_tlast_reg <= res_done;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    // ------------------------------------------------------------------
    // Checks on the decoder's own logic.
    // ------------------------------------------------------------------
    a_data_run_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_DATA) |-> (run_left_reg != '0))
        else $error("literal run phase with no bytes left");

    a_offset_not_below_base: assert property (@(posedge aclk) disable iff (!aresetn)
        pixel_offset_reg >= row_base_reg)
        else $error("pixel offset fell below the row start");

    a_done_only_on_row_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_tlast_reg) |-> (m_tuser_reg == KIND_ROW_END))
        else $error("frame done flagged on a pixel write");

    a_row_end_index_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_tuser_reg == KIND_ROW_END) |-> (m_tdata_reg[27:20] == '0))
        else $error("row end carries a palette index");

    a_input_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !proc_fire) |=> in_valid_reg)
        else $error("waiting input item was dropped");

endmodule
